/* src/ptd_pkg.sv */
// ptd_pkg: shared widths, codes and control/status structs of the phased task dispatcher
// no dependencies; used by every module of the block
package ptd_pkg;

	// payload and configuration widths
	localparam int ACTION_W   = 1;
	localparam int KIND_W     = 2;
	localparam int IDX_W      = 6;
	localparam int REPLY_W    = 2;
	localparam int MAP_CNT_W  = 7;
	localparam int RED_CNT_W  = 5;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W  = 1;

	// default capacities
	localparam int MAX_MAP_TASKS_DEF    = 64;
	localparam int MAX_REDUCE_TASKS_DEF = 16;

	// scan row: marks examined per cycle
	localparam int LANE_W     = 3;
	localparam int SCAN_LANES = 1 << LANE_W;

	// request action codes
	localparam logic [ACTION_W-1:0] ACT_ASK    = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_SUBMIT = 1'b1;

	// submitted task kinds
	localparam logic [KIND_W-1:0] KIND_MAP    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REDUCE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MERGE  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_COUNT    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_COUNT = 1'b1;

	// reply codes
	typedef enum logic [REPLY_W-1:0] {
		REPLY_NONE   = 2'd0,
		REPLY_MAP    = 2'd1,
		REPLY_REDUCE = 2'd2,
		REPLY_MERGE  = 2'd3
	} reply_t;

	// status of one mark bank at the current scan row
	typedef struct packed {
		logic hit;     // an unstarted task in use sits in this row
		logic last;    // this row is the last one holding tasks in use
		logic pending; // an unfinished task seen in this or an earlier row
	} bank_stat_t;

	// datapath status toward the controller
	typedef struct packed {
		bank_stat_t map_st;
		bank_stat_t red_st;
		logic       merge_free;
	} dp_stat_t;

	// controller commands toward the datapath
	typedef struct packed {
		logic   capture;  // latch the accepted request word
		logic   scan_clr; // rewind both scans
		logic   map_step; // advance the map scan by one row
		logic   red_step; // advance the reduce scan by one row
		logic   commit;   // apply the update and load the result word
		reply_t reply;    // reply chosen for this request
	} dp_cmd_t;

endpackage

/* src/ptd_bank.sv */
// ptd_bank: started/finished marks of one task kind with a row-at-a-time first-unstarted scan
// depends on ptd_pkg
module ptd_bank #(
	parameter int MAX_TASKS = ptd_pkg::MAX_MAP_TASKS_DEF,
	parameter int CNT_W     = ptd_pkg::MAP_CNT_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [CNT_W-1:0]         cnt,
	input  logic                     scan_clr,
	input  logic                     scan_step,
	input  logic                     grant,
	input  logic                     submit,
	input  logic [ptd_pkg::IDX_W-1:0] sub_idx,
	output ptd_pkg::bank_stat_t      stat,
	output logic [ptd_pkg::IDX_W-1:0] gnt_idx,
	output logic                     sub_ok
);

	// a count register can never name more than its largest value
	localparam int DEPTH_CAP = (1 << CNT_W) - 1;
	localparam int DEPTH     = (MAX_TASKS < DEPTH_CAP) ? MAX_TASKS : DEPTH_CAP;
	localparam int LANES     = ptd_pkg::SCAN_LANES;
	localparam int LANE_W    = ptd_pkg::LANE_W;
	localparam int ROWS_USED = (DEPTH + LANES - 1) / LANES;
	localparam int ROW_W     = (ROWS_USED > 1) ? $clog2(ROWS_USED) : 1;
	localparam int NROW      = 1 << ROW_W;
	localparam int POS_W     = ROW_W + LANE_W;
	localparam int MAX_A     = (POS_W > CNT_W) ? POS_W : CNT_W;
	localparam int MAX_B     = (MAX_A > ptd_pkg::IDX_W) ? MAX_A : ptd_pkg::IDX_W;
	localparam int CMP_W     = MAX_B + 1;

	logic [NROW-1:0][LANES-1:0] started_q;
	logic [NROW-1:0][LANES-1:0] finished_q;
	logic [ROW_W-1:0]           row_q;
	logic                       pending_q;

	logic [CNT_W-1:0]  n_use;
	logic [LANES-1:0]  lane_unstarted;
	logic [LANES-1:0]  lane_unfin;
	logic [LANE_W-1:0] hit_lane;
	logic [CMP_W-1:0]  rows_in_use;
	logic [POS_W-1:0]  sub_pos;
	logic [POS_W-1:0]  hit_pos;

	// saturate the configured count to the storage depth
	assign n_use = (cnt > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cnt;

	// classify the marks of the current row
	always_comb begin
		lane_unstarted = '0;
		lane_unfin     = '0;
		for (int k = 0; k < LANES; k++) begin
			if (CMP_W'({row_q, LANE_W'(k)}) < CMP_W'(n_use)) begin
				lane_unstarted[k] = !started_q[row_q][k] && !finished_q[row_q][k];
				lane_unfin[k]     = !finished_q[row_q][k];
			end
		end
	end

	// lowest unstarted lane of the row
	always_comb begin
		hit_lane = '0;
		for (int k = LANES - 1; k >= 0; k--) begin
			if (lane_unstarted[k]) begin
				hit_lane = LANE_W'(k);
			end
		end
	end

	// rows that hold tasks in use, rounded up
	assign rows_in_use = (CMP_W'(n_use) + CMP_W'(LANES - 1)) >> LANE_W;

	assign stat.hit     = |lane_unstarted;
	assign stat.last    = (CMP_W'(row_q) + CMP_W'(1)) >= rows_in_use;
	assign stat.pending = pending_q || (|lane_unfin);

	assign hit_pos = {row_q, hit_lane};
	assign gnt_idx = ptd_pkg::IDX_W'(hit_pos);

	// submit index check and mark address
	assign sub_ok  = CMP_W'(sub_idx) < CMP_W'(n_use);
	assign sub_pos = POS_W'(sub_idx);

	// scan position and pending accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			pending_q <= 1'b0;
		end else if (scan_clr) begin
			row_q     <= '0;
			pending_q <= 1'b0;
		end else if (scan_step) begin
			row_q     <= row_q + ROW_W'(1);
			pending_q <= pending_q || (|lane_unfin);
		end
	end

	// task marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= '0;
			finished_q <= '0;
		end else begin
			if (grant) begin
				started_q[row_q][hit_lane] <= 1'b1;
			end
			if (submit && sub_ok) begin
				finished_q[sub_pos[POS_W-1:LANE_W]][sub_pos[LANE_W-1:0]] <= 1'b1;
			end
		end
	end

endmodule

/* src/ptd_dpath.sv */
// ptd_dpath: count registers, request and result words, merge mark and the two mark banks
// depends on ptd_pkg and ptd_bank
module ptd_dpath #(
	parameter int MAX_MAP_TASKS    = ptd_pkg::MAX_MAP_TASKS_DEF,
	parameter int MAX_REDUCE_TASKS = ptd_pkg::MAX_REDUCE_TASKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ptd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [ptd_pkg::ACTION_W-1:0]   action,
	input  logic [ptd_pkg::KIND_W-1:0]     task_kind,
	input  logic [ptd_pkg::IDX_W-1:0]      task_index,
	input  ptd_pkg::dp_cmd_t              cmd,
	output ptd_pkg::dp_stat_t             stat,
	output logic [ptd_pkg::REPLY_W-1:0]    reply_kind,
	output logic [ptd_pkg::IDX_W-1:0]      granted_index,
	output logic                          bad_index,
	output logic                          job_done
);

	logic [ptd_pkg::MAP_CNT_W-1:0] map_task_count_q;
	logic [ptd_pkg::RED_CNT_W-1:0] reduce_task_count_q;
	logic [ptd_pkg::ACTION_W-1:0]  action_q;
	logic [ptd_pkg::KIND_W-1:0]    kind_q;
	logic [ptd_pkg::IDX_W-1:0]     idx_q;
	logic                          merge_started_q;
	logic                          job_done_q;
	ptd_pkg::reply_t               reply_kind_q;
	logic [ptd_pkg::IDX_W-1:0]     granted_index_q;
	logic                          bad_index_q;
	logic                          job_done_out_q;

	logic                      is_submit;
	logic                      sub_map;
	logic                      sub_red;
	logic                      sub_merge;
	logic                      map_sub_ok;
	logic                      red_sub_ok;
	logic [ptd_pkg::IDX_W-1:0] map_gnt_idx;
	logic [ptd_pkg::IDX_W-1:0] red_gnt_idx;
	logic                      bad_nxt;
	logic                      done_nxt;
	logic [ptd_pkg::IDX_W-1:0] gnt_nxt;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_task_count_q    <= '0;
			reduce_task_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptd_pkg::CFG_MAP_COUNT: begin
					map_task_count_q <= cfg_data;
				end
				ptd_pkg::CFG_REDUCE_COUNT: begin
					reduce_task_count_q <= cfg_data[ptd_pkg::RED_CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// accepted request word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action;
			kind_q   <= task_kind;
			idx_q    <= task_index;
		end
	end

	// submit decode
	assign is_submit = (action_q == ptd_pkg::ACT_SUBMIT);
	assign sub_map   = is_submit && (kind_q == ptd_pkg::KIND_MAP);
	assign sub_red   = is_submit && (kind_q == ptd_pkg::KIND_REDUCE);
	assign sub_merge = is_submit && (kind_q == ptd_pkg::KIND_MERGE);

	// map and reduce mark banks
	ptd_bank #(
		.MAX_TASKS (MAX_MAP_TASKS),
		.CNT_W     (ptd_pkg::MAP_CNT_W)
	) u_map_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.cnt       (map_task_count_q),
		.scan_clr  (cmd.scan_clr),
		.scan_step (cmd.map_step),
		.grant     (cmd.commit && (cmd.reply == ptd_pkg::REPLY_MAP)),
		.submit    (cmd.commit && sub_map),
		.sub_idx   (idx_q),
		.stat      (stat.map_st),
		.gnt_idx   (map_gnt_idx),
		.sub_ok    (map_sub_ok)
	);

	ptd_bank #(
		.MAX_TASKS (MAX_REDUCE_TASKS),
		.CNT_W     (ptd_pkg::RED_CNT_W)
	) u_red_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.cnt       (reduce_task_count_q),
		.scan_clr  (cmd.scan_clr),
		.scan_step (cmd.red_step),
		.grant     (cmd.commit && (cmd.reply == ptd_pkg::REPLY_REDUCE)),
		.submit    (cmd.commit && sub_red),
		.sub_idx   (idx_q),
		.stat      (stat.red_st),
		.gnt_idx   (red_gnt_idx),
		.sub_ok    (red_sub_ok)
	);

	assign stat.merge_free = !merge_started_q && !job_done_q;

	// result fields of the current request
	always_comb begin
		bad_nxt = 1'b0;
		if (is_submit) begin
			priority if (sub_map) begin
				bad_nxt = !map_sub_ok;
			end else if (sub_red) begin
				bad_nxt = !red_sub_ok;
			end else if (sub_merge) begin
				bad_nxt = 1'b0;
			end else begin
				bad_nxt = 1'b1;
			end
		end
	end

	assign done_nxt = job_done_q || (cmd.commit && sub_merge);

	always_comb begin
		unique case (cmd.reply)
			ptd_pkg::REPLY_MAP:    gnt_nxt = map_gnt_idx;
			ptd_pkg::REPLY_REDUCE: gnt_nxt = red_gnt_idx;
			default:               gnt_nxt = '0;
		endcase
	end

	// merge mark and job done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_started_q <= 1'b0;
			job_done_q      <= 1'b0;
		end else if (cmd.commit) begin
			if (cmd.reply == ptd_pkg::REPLY_MERGE) begin
				merge_started_q <= 1'b1;
			end
			if (sub_merge) begin
				job_done_q <= 1'b1;
			end
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			reply_kind_q    <= cmd.reply;
			granted_index_q <= gnt_nxt;
			bad_index_q     <= bad_nxt;
			job_done_out_q  <= done_nxt;
		end
	end

	assign reply_kind    = reply_kind_q;
	assign granted_index = granted_index_q;
	assign bad_index     = bad_index_q;
	assign job_done      = job_done_out_q;

endmodule

/* src/ptd_ctrl.sv */
// ptd_ctrl: request sequencer and result handshake of the phased task dispatcher
// depends on ptd_pkg
module ptd_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ptd_pkg::ACTION_W-1:0] action,
	output logic                        out_valid,
	input  logic                        out_ready,
	input  ptd_pkg::dp_stat_t           stat,
	output ptd_pkg::dp_cmd_t            cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MAP  = 4'b0010,
		ST_RED  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t          state_q;
	state_t          state_nxt;
	ptd_pkg::reply_t reply_q;
	ptd_pkg::reply_t reply_nxt;
	logic            out_valid_q;
	logic            out_free;

	// result slot can take a word when empty or being drained
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// next state, reply choice and commands
	always_comb begin
		state_nxt = state_q;
		reply_nxt = reply_q;
		cmd       = '0;
		cmd.reply = reply_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture  = 1'b1;
					cmd.scan_clr = 1'b1;
					reply_nxt    = ptd_pkg::REPLY_NONE;
					state_nxt    = (action == ptd_pkg::ACT_ASK) ? ST_MAP : ST_DONE;
				end
			end
			ST_MAP: begin
				priority if (stat.map_st.hit) begin
					reply_nxt = ptd_pkg::REPLY_MAP;
					state_nxt = ST_DONE;
				end else if (stat.map_st.last) begin
					state_nxt = stat.map_st.pending ? ST_DONE : ST_RED;
				end else begin
					cmd.map_step = 1'b1;
				end
			end
			ST_RED: begin
				priority if (stat.red_st.hit) begin
					reply_nxt = ptd_pkg::REPLY_REDUCE;
					state_nxt = ST_DONE;
				end else if (stat.red_st.last) begin
					if (!stat.red_st.pending && stat.merge_free) begin
						reply_nxt = ptd_pkg::REPLY_MERGE;
					end
					state_nxt = ST_DONE;
				end else begin
					cmd.red_step = 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state and reply registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			reply_q <= ptd_pkg::REPLY_NONE;
		end else begin
			state_q <= state_nxt;
			reply_q <= reply_nxt;
		end
	end

	// result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

/* src/phased_task_dispatcher_top.sv */
// phased_task_dispatcher_top: three-phase task dispatcher, controller plus datapath
// depends on ptd_pkg, ptd_ctrl, ptd_dpath (and ptd_bank below it)
//
//  channel   handshake             word
//  request   in_valid / in_ready   action, task_kind, task_index
//  result    out_valid / out_ready reply_kind, granted_index, bad_index, job_done
//  config    cfg_we                cfg_index, cfg_data (0 map count, 1 reduce count)
//
// A submit passes from the accepting cycle to a commit cycle that loads the result word; the
// commit waits while the result slot is full. An ask scans the map marks, one row of 8 per
// cycle, and the reduce marks only once every map is finished, then commits; each phase costs
// at least one row, in all at most max(1, ceil(maps/8)) + max(1, ceil(reduces/8)) rows.
// Reset marks every task unstarted and clears both counts and job done.
// A result word waits while out_ready is low; a new request is taken and commits once it is free.
module phased_task_dispatcher_top #(
	parameter int MAX_MAP_TASKS    = ptd_pkg::MAX_MAP_TASKS_DEF,
	parameter int MAX_REDUCE_TASKS = ptd_pkg::MAX_REDUCE_TASKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ptd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ptd_pkg::ACTION_W-1:0]   action,
	input  logic [ptd_pkg::KIND_W-1:0]     task_kind,
	input  logic [ptd_pkg::IDX_W-1:0]      task_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ptd_pkg::REPLY_W-1:0]    reply_kind,
	output logic [ptd_pkg::IDX_W-1:0]      granted_index,
	output logic                          bad_index,
	output logic                          job_done
);

	ptd_pkg::dp_cmd_t  cmd;
	ptd_pkg::dp_stat_t stat;

	// sequencer
	ptd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// marks, counts and result word
	ptd_dpath #(
		.MAX_MAP_TASKS    (MAX_MAP_TASKS),
		.MAX_REDUCE_TASKS (MAX_REDUCE_TASKS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.action        (action),
		.task_kind     (task_kind),
		.task_index    (task_index),
		.cmd           (cmd),
		.stat          (stat),
		.reply_kind    (reply_kind),
		.granted_index (granted_index),
		.bad_index     (bad_index),
		.job_done      (job_done)
	);

endmodule

/* sim/phased_task_dispatcher_top_tb.sv */
// phased_task_dispatcher_top_tb: self-checking bench for the three-phase task dispatcher
// depends on ptd_pkg and phased_task_dispatcher_top; predicts every result word in a scoreboard
// directed job walk-through first, then random rounds of asks and submits with count changes
module phased_task_dispatcher_top_tb;

	localparam int MAX_MAPS     = ptd_pkg::MAX_MAP_TASKS_DEF;
	localparam int MAX_REDUCES  = ptd_pkg::MAX_REDUCE_TASKS_DEF;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int ROUNDS       = 12;
	localparam int ROUND_WORDS  = 100;
	localparam int LATE_ROUND   = 8;
	localparam int REPORT_LIMIT = 10;

	// task kind code with no meaning in the block
	localparam logic [ptd_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		TASK_UNSTARTED,
		TASK_STARTED,
		TASK_FINISHED
	} mark_t;

	typedef enum logic [1:0] {
		SCAN_CLEAR, // every task in use finished
		SCAN_BUSY,  // some unfinished, none unstarted
		SCAN_FREE   // an unstarted task was found
	} scan_t;

	typedef struct packed {
		ptd_pkg::reply_t           reply;
		logic [ptd_pkg::IDX_W-1:0] granted;
		logic                      bad;
		logic                      done;
	} dispatch_word_t;

	typedef struct {
		logic [ptd_pkg::KIND_W-1:0] kind;
		logic [ptd_pkg::IDX_W-1:0]  idx;
	} task_ref_t;

	// task bookkeeping and expected result words
	class dispatch_scoreboard_t;
		mark_t          map_mark[MAX_MAPS];
		mark_t          reduce_mark[MAX_REDUCES];
		mark_t          merge_mark;
		bit             job_finished;
		int unsigned    map_count;
		int unsigned    reduce_count;
		dispatch_word_t expected_words[$];
		int unsigned    mismatches;

		function new();
			foreach (map_mark[i]) map_mark[i] = TASK_UNSTARTED;
			foreach (reduce_mark[i]) reduce_mark[i] = TASK_UNSTARTED;
			merge_mark = TASK_UNSTARTED;
			job_finished = 1'b0;
			map_count = 0;
			reduce_count = 0;
			mismatches = 0;
		endfunction

		function int unsigned maps_live();
			return (map_count > MAX_MAPS) ? MAX_MAPS : map_count;
		endfunction

		function int unsigned reduces_live();
			return (reduce_count > MAX_REDUCES) ? MAX_REDUCES : reduce_count;
		endfunction

		// lowest unstarted task of one bank, or whether the bank is still busy
		function scan_t scan_bank(bit reduce_bank, output int unsigned pos);
			int unsigned n;
			int unsigned i;
			bit open_work;
			mark_t m;
			n = reduce_bank ? reduces_live() : maps_live();
			open_work = 1'b0;
			pos = 0;
			for (i = 0; i < n; i++) begin
				m = reduce_bank ? reduce_mark[i] : map_mark[i];
				if (m == TASK_UNSTARTED) begin
					pos = i;
					return SCAN_FREE;
				end
				if (m != TASK_FINISHED)
					open_work = 1'b1;
			end
			return open_work ? SCAN_BUSY : SCAN_CLEAR;
		endfunction

		// apply one accepted request word and queue its result
		function dispatch_word_t predict_request(logic [ptd_pkg::ACTION_W-1:0] act,
				logic [ptd_pkg::KIND_W-1:0] kind, logic [ptd_pkg::IDX_W-1:0] idx);
			dispatch_word_t w;
			int unsigned pos;
			scan_t st;
			w = '{ptd_pkg::REPLY_NONE, '0, 1'b0, 1'b0};
			if (act == ptd_pkg::ACT_ASK) begin
				st = scan_bank(1'b0, pos);
				if (st == SCAN_FREE) begin
					map_mark[pos] = TASK_STARTED;
					w.reply = ptd_pkg::REPLY_MAP;
					w.granted = pos[ptd_pkg::IDX_W-1:0];
				end else if (st == SCAN_CLEAR) begin
					st = scan_bank(1'b1, pos);
					if (st == SCAN_FREE) begin
						reduce_mark[pos] = TASK_STARTED;
						w.reply = ptd_pkg::REPLY_REDUCE;
						w.granted = pos[ptd_pkg::IDX_W-1:0];
					end else if (st == SCAN_CLEAR && merge_mark == TASK_UNSTARTED) begin
						merge_mark = TASK_STARTED;
						w.reply = ptd_pkg::REPLY_MERGE;
					end
				end
			end else begin
				case (kind)
					ptd_pkg::KIND_MAP: begin
						if (idx < maps_live())
							map_mark[idx] = TASK_FINISHED;
						else
							w.bad = 1'b1;
					end
					ptd_pkg::KIND_REDUCE: begin
						if (idx < reduces_live())
							reduce_mark[idx] = TASK_FINISHED;
						else
							w.bad = 1'b1;
					end
					ptd_pkg::KIND_MERGE: begin
						merge_mark = TASK_FINISHED;
						job_finished = 1'b1;
					end
					default: w.bad = 1'b1;
				endcase
			end
			w.done = job_finished;
			expected_words.push_back(w);
			return w;
		endfunction

		// compare one accepted result word with the oldest expectation
		function void check_reply(dispatch_word_t got);
			dispatch_word_t want;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result word: reply %0d index %0d bad %0d done %0d",
						got.reply, got.granted, got.bad, got.done);
				return;
			end
			want = expected_words.pop_front();
			if (got.reply !== want.reply || got.granted !== want.granted ||
					got.bad !== want.bad || got.done !== want.done) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("mismatch: expected reply %0d index %0d bad %0d done %0d, %s %0d %0d %0d %0d",
						want.reply, want.granted, want.bad, want.done, "got",
						got.reply, got.granted, got.bad, got.done);
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [ptd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [ptd_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           in_valid;
	logic                           in_ready;
	logic [ptd_pkg::ACTION_W-1:0]   action;
	logic [ptd_pkg::KIND_W-1:0]     task_kind;
	logic [ptd_pkg::IDX_W-1:0]      task_index;
	logic                           out_valid;
	logic                           out_ready;
	logic [ptd_pkg::REPLY_W-1:0]    reply_kind;
	logic [ptd_pkg::IDX_W-1:0]      granted_index;
	logic                           bad_index;
	logic                           job_done;

	dispatch_scoreboard_t sb;
	task_ref_t            handed_out[$];
	int                   send_quiet;
	int                   recv_quiet;
	int unsigned          cycle_count;

	phased_task_dispatcher_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.task_kind     (task_kind),
		.task_index    (task_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.reply_kind    (reply_kind),
		.granted_index (granted_index),
		.bad_index     (bad_index),
		.job_done      (job_done)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// per-word wait, with occasional stretches of back-to-back words
	function automatic int draw_wait(inout int quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			quiet_left = $urandom_range(10, 40);
		return $urandom_range(0, 15);
	endfunction

	// send one request word and track the tasks it hands out or finishes
	task automatic issue_word(input logic [ptd_pkg::ACTION_W-1:0] act,
			input logic [ptd_pkg::KIND_W-1:0] kind, input logic [ptd_pkg::IDX_W-1:0] idx);
		int gap;
		dispatch_word_t w;
		gap = draw_wait(send_quiet);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		task_kind <= kind;
		task_index <= idx;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		w = sb.predict_request(act, kind, idx);
		if (w.reply == ptd_pkg::REPLY_MAP)
			handed_out.push_back('{ptd_pkg::KIND_MAP, w.granted});
		else if (w.reply == ptd_pkg::REPLY_REDUCE)
			handed_out.push_back('{ptd_pkg::KIND_REDUCE, w.granted});
		if (act == ptd_pkg::ACT_SUBMIT && !w.bad) begin
			foreach (handed_out[i]) begin
				if (handed_out[i].kind == kind && handed_out[i].idx == idx) begin
					handed_out.delete(i);
					break;
				end
			end
		end
	endtask

	// hold off the sender until every expected word has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_words.size() != 0) @(negedge clk);
	endtask

	// write both task counts while the block is idle
	task automatic reconfigure(input int unsigned maps, input int unsigned reduces);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= ptd_pkg::CFG_MAP_COUNT;
		cfg_data <= maps[ptd_pkg::CFG_DATA_W-1:0];
		sb.map_count = 32'(maps[ptd_pkg::MAP_CNT_W-1:0]);
		@(negedge clk);
		cfg_index <= ptd_pkg::CFG_REDUCE_COUNT;
		cfg_data <= {{(ptd_pkg::CFG_DATA_W-ptd_pkg::RED_CNT_W){1'b0}},
			reduces[ptd_pkg::RED_CNT_W-1:0]};
		sb.reduce_count = 32'(reduces[ptd_pkg::RED_CNT_W-1:0]);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// result side: random stalls, check each accepted word
	initial begin
		out_ready = 1'b0;
		recv_quiet = 0;
		forever begin
			int stall;
			stall = draw_wait(recv_quiet);
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			sb.check_reply('{ptd_pkg::reply_t'(reply_kind), granted_index, bad_index,
				job_done});
		end
	end

	// request side: directed walk-through, then random rounds
	initial begin
		int unsigned map_n;
		int unsigned red_n;
		int unsigned pick;
		int unsigned j;
		logic [ptd_pkg::KIND_W-1:0] k;
		sb = new();
		send_quiet = 0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ptd_pkg::ACT_ASK;
		task_kind = ptd_pkg::KIND_MAP;
		task_index = '0;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// no tasks in either phase: the merge goes out at once
		issue_word(ptd_pkg::ACT_ASK, ptd_pkg::KIND_MAP, 6'd0);

		// small job: hand out every map, then one left busy
		reconfigure(3, 2);
		issue_word(ptd_pkg::ACT_ASK, KIND_UNUSED, 6'd63);
		issue_word(ptd_pkg::ACT_ASK, ptd_pkg::KIND_MAP, 6'd0);
		issue_word(ptd_pkg::ACT_ASK, ptd_pkg::KIND_REDUCE, 6'd21);
		issue_word(ptd_pkg::ACT_ASK, ptd_pkg::KIND_MERGE, 6'd42);

		// bad kind, out-of-range indexes, submit of a task never handed out
		issue_word(ptd_pkg::ACT_SUBMIT, KIND_UNUSED, 6'd63);
		issue_word(ptd_pkg::ACT_SUBMIT, ptd_pkg::KIND_MAP, 6'd3);
		issue_word(ptd_pkg::ACT_SUBMIT, ptd_pkg::KIND_REDUCE, 6'd2);
		issue_word(ptd_pkg::ACT_SUBMIT, ptd_pkg::KIND_REDUCE, 6'd0);

		// finish the map phase, then the reduce phase
		issue_word(ptd_pkg::ACT_SUBMIT, ptd_pkg::KIND_MAP, 6'd1);
		issue_word(ptd_pkg::ACT_SUBMIT, ptd_pkg::KIND_MAP, 6'd0);
		issue_word(ptd_pkg::ACT_ASK, ptd_pkg::KIND_MAP, 6'd0);
		issue_word(ptd_pkg::ACT_SUBMIT, ptd_pkg::KIND_MAP, 6'd2);
		issue_word(ptd_pkg::ACT_ASK, ptd_pkg::KIND_MAP, 6'd0);
		issue_word(ptd_pkg::ACT_ASK, ptd_pkg::KIND_MAP, 6'd0);
		issue_word(ptd_pkg::ACT_SUBMIT, ptd_pkg::KIND_REDUCE, 6'd1);
		issue_word(ptd_pkg::ACT_ASK, ptd_pkg::KIND_MAP, 6'd0);

		// counts above the capacity saturate
		reconfigure(127, 31);
		issue_word(ptd_pkg::ACT_ASK, ptd_pkg::KIND_MAP, 6'd0);
		issue_word(ptd_pkg::ACT_SUBMIT, ptd_pkg::KIND_MAP, 6'd63);
		issue_word(ptd_pkg::ACT_SUBMIT, ptd_pkg::KIND_REDUCE, 6'd16);

		// random rounds, each with its own task counts
		for (int round = 0; round < ROUNDS; round++) begin
			case (round)
				0: begin
					map_n = 0;
					red_n = 5;
				end
				ROUNDS - 2: begin
					map_n = 127;
					red_n = 31;
				end
				ROUNDS - 1: begin
					map_n = MAX_MAPS;
					red_n = MAX_REDUCES;
				end
				default: begin
					if ($urandom_range(0, 3) == 0) begin
						map_n = $urandom_range(0, 127);
						red_n = $urandom_range(0, 31);
					end else begin
						map_n = $urandom_range(0, 6 * (round + 1));
						red_n = $urandom_range(0, 2 * (round + 1));
					end
				end
			endcase
			reconfigure(map_n, red_n);

			// the merge finishes late so most of the run sees job done low
			if (round == LATE_ROUND)
				issue_word(ptd_pkg::ACT_SUBMIT, ptd_pkg::KIND_MERGE,
					ptd_pkg::IDX_W'($urandom_range(0, 63)));

			for (int n = 0; n < ROUND_WORDS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 85 && pick >= 45 && handed_out.size() != 0) begin
					j = $urandom_range(0, handed_out.size() - 1);
					issue_word(ptd_pkg::ACT_SUBMIT, handed_out[j].kind, handed_out[j].idx);
				end else if (pick < 85) begin
					issue_word(ptd_pkg::ACT_ASK, ptd_pkg::KIND_W'($urandom_range(0, 3)),
						ptd_pkg::IDX_W'($urandom_range(0, 63)));
				end else begin
					k = ptd_pkg::KIND_W'($urandom_range(0, 3));
					if (round < LATE_ROUND && k == ptd_pkg::KIND_MERGE)
						k = KIND_UNUSED;
					issue_word(ptd_pkg::ACTION_W'($urandom_range(0, 1)), k,
						ptd_pkg::IDX_W'($urandom_range(0, 63)));
				end
			end
		end

		// let the last words come back, then watch for strays
		drain();
		repeat (40) @(negedge clk);
		if (sb.mismatches == 0 && sb.expected_words.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
